// File: rtl/sbp_pkg.sv
`timescale 1ns / 1ps
// shared constants, register codes and arctangent table of the sprite billboard projection unit
package sbp_pkg;

  // pipelined divider geometry
  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_ROWS   = 2'd1,
    CFG_WORLD_UNIT    = 2'd2,
    CFG_FIELD_OF_VIEW = 2'd3
  } cfg_idx_t;

  // cordic datapath
  localparam int unsigned CORDIC_XW = 36;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // arctangent of 2^-idx, 2^32 per turn
  function automatic logic [31:0] atan_entry(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/sprite_billboard_projection_unit.sv
`timescale 1ns / 1ps
// sprite billboard projection unit: distance, bearing, projected size and screen position
//
// One sprite is taken at every clock edge where start is high; busy stays low, so a new
// sprite may follow in every cycle. Each sprite gives exactly one result, shown for one
// cycle with out_valid high. The receiver cannot hold results off, and none are needed:
// the pipeline never stalls. The pipeline runs through the vectoring cordic (one stage per
// iteration) and the two chained 33-stage dividers (height, then width); the column
// divider runs beside the height divider. Configuration registers are read by the
// pipeline as it runs, so write them only when no sprite is in flight.
module sprite_billboard_projection_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input transfer
  input  logic                           start,
  output logic                           busy,
  input  logic signed [23:0]             in_sprite_pos_x,
  input  logic signed [23:0]             in_sprite_pos_y,
  input  logic signed [23:0]             in_viewer_x,
  input  logic signed [23:0]             in_viewer_y,
  input  logic [15:0]                    in_view_angle,
  input  logic [12:0]                    in_frame_w,
  input  logic [12:0]                    in_frame_h,
  // configuration writes
  input  logic                           cfg_we,
  input  sbp_pkg::cfg_idx_t              cfg_index,
  input  logic [sbp_pkg::CFG_DATA_W-1:0] cfg_data,
  // result transfer
  output logic                           out_valid,
  output logic [23:0]                    out_distance_out,
  output logic signed [15:0]             out_relative_bearing,
  output logic [19:0]                    out_proj_height,
  output logic [19:0]                    out_proj_width,
  output logic signed [20:0]             out_left_column,
  output logic signed [20:0]             out_top_row,
  output logic                           out_visible
);
  import sbp_pkg::*;

  localparam int unsigned CN = CORDIC_STAGES;
  localparam int unsigned XW = CORDIC_XW;
  localparam int unsigned DL = DIV_NUM_W;

  localparam logic [19:0] SIZE_MAX = 20'hFFFFF;

  // cordic stage payload
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
    logic [15:0]          view;
    logic [12:0]          fw;
    logic [12:0]          fh;
  } cor_t;

  // sideband riding beside the column divider
  typedef struct packed {
    logic                neg;
    logic [23:0]         d;
    logic signed [15:0]  bear;
    logic [12:0]         fw;
    logic [12:0]         fh;
  } sb1_t;

  // sideband riding beside the width divider
  typedef struct packed {
    logic [19:0]         hs;
    logic signed [30:0]  c;
    logic [23:0]         d;
    logic signed [15:0]  bear;
  } sb2_t;

  // the pipeline never stalls, so a sprite can always be taken
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [12:0] sw_r;
  logic [12:0] sh_r;
  logic [8:0]  tile_r;
  logic [15:0] fov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r   <= 13'd640;
      sh_r   <= 13'd480;
      tile_r <= 9'd64;
      fov_r  <= 16'd10923;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  sw_r   <= cfg_data[12:0];
        CFG_SCREEN_ROWS:   sh_r   <= cfg_data[12:0];
        CFG_WORLD_UNIT:    tile_r <= cfg_data[8:0];
        CFG_FIELD_OF_VIEW: fov_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // zero field of view reads as one
  logic [15:0] fovn;
  assign fovn = (fov_r == 16'd0) ? 16'd1 : fov_r;

  // ---------------------------------------------------------------------------
  // p0: offsets from viewer to sprite
  // ---------------------------------------------------------------------------
  logic               p0_v_r;
  logic signed [24:0] p0_dx_r;
  logic signed [24:0] p0_dy_r;
  logic [15:0]        p0_view_r;
  logic [12:0]        p0_fw_r;
  logic [12:0]        p0_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else begin
      p0_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    p0_dx_r   <= {in_sprite_pos_x[23], in_sprite_pos_x} - {in_viewer_x[23], in_viewer_x};
    p0_dy_r   <= {in_sprite_pos_y[23], in_sprite_pos_y} - {in_viewer_y[23], in_viewer_y};
    p0_view_r <= in_view_angle;
    p0_fw_r   <= in_frame_w;
    p0_fh_r   <= in_frame_h;
  end

  // ---------------------------------------------------------------------------
  // cordic: half turn pre-rotation, then one vectoring step per stage
  // ---------------------------------------------------------------------------
  logic cor_v_r [CN+1];
  cor_t cor_r   [CN+1];

  logic signed [XW-1:0] pre_x;
  logic signed [XW-1:0] pre_y;
  logic                 pre_neg;

  // guard bits: offsets move to q.8
  assign pre_x   = {{3{p0_dx_r[24]}}, p0_dx_r, 8'd0};
  assign pre_y   = {{3{p0_dy_r[24]}}, p0_dy_r, 8'd0};
  assign pre_neg = p0_dx_r[24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cor_v_r[0] <= 1'b0;
    end else begin
      cor_v_r[0] <= p0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cor_r[0].x    <= pre_neg ? -pre_x : pre_x;
    cor_r[0].y    <= pre_neg ? -pre_y : pre_y;
    cor_r[0].z    <= pre_neg ? 32'h80000000 : 32'h00000000;
    cor_r[0].zero <= (p0_dx_r == 25'sd0) && (p0_dy_r == 25'sd0);
    cor_r[0].view <= p0_view_r;
    cor_r[0].fw   <= p0_fw_r;
    cor_r[0].fh   <= p0_fh_r;
  end

  for (genvar i = 0; i < CN; i++) begin : g_cordic
    cor_t cur;
    cor_t cor_nxt;

    assign cur = cor_r[i];

    // arithmetic shifts floor toward minus infinity
    always_comb begin
      cor_nxt = cur;
      if (!cur.y[XW-1]) begin
        cor_nxt.x = cur.x + (cur.y >>> i);
        cor_nxt.y = cur.y - (cur.x >>> i);
        cor_nxt.z = cur.z + atan_entry(i);
      end else begin
        cor_nxt.x = cur.x - (cur.y >>> i);
        cor_nxt.y = cur.y + (cur.x >>> i);
        cor_nxt.z = cur.z - atan_entry(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cor_v_r[i+1] <= 1'b0;
      end else begin
        cor_v_r[i+1] <= cor_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      cor_r[i+1] <= cor_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // m: gain correction product and relative bearing
  // ---------------------------------------------------------------------------
  cor_t        cor_end;
  logic [34:0] m_xmag;
  logic [31:0] m_zrnd;

  assign cor_end = cor_r[CN];
  // coincident positions give zero angle and zero length
  assign m_xmag  = cor_end.zero ? 35'd0 : cor_end.x[34:0];
  assign m_zrnd  = (cor_end.zero ? 32'd0 : cor_end.z) + 32'h00008000;

  logic               m_v_r;
  logic [50:0]        m_prod_r;
  logic signed [15:0] m_bear_r;
  logic [12:0]        m_fw_r;
  logic [12:0]        m_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= cor_v_r[CN];
    end
  end

  always_ff @(posedge clk) begin
    m_prod_r <= m_xmag * INV_GAIN_Q16;
    m_bear_r <= m_zrnd[31:16] - cor_end.view;
    m_fw_r   <= cor_end.fw;
    m_fh_r   <= cor_end.fh;
  end

  // ---------------------------------------------------------------------------
  // e: rounded, clamped distance and column numerator
  // ---------------------------------------------------------------------------
  logic [50:0] e_sum;
  logic [26:0] e_dq;
  logic [23:0] e_dclamp;

  assign e_sum    = m_prod_r + 51'h800000;
  assign e_dq     = e_sum[50:24];
  assign e_dclamp = (e_dq < 27'd256)      ? 24'd256 :
                    (e_dq > 27'hFFFFFF)   ? 24'hFFFFFF : e_dq[23:0];

  logic               e_v_r;
  logic [23:0]        e_d_r;
  logic signed [15:0] e_bear_r;
  logic signed [17:0] e_ncol_r;
  logic [12:0]        e_fw_r;
  logic [12:0]        e_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    e_d_r    <= e_dclamp;
    e_bear_r <= m_bear_r;
    e_ncol_r <= {m_bear_r[15], m_bear_r, 1'b0} + {2'b00, fovn};
    e_fw_r   <= m_fw_r;
    e_fh_r   <= m_fh_r;
  end

  // ---------------------------------------------------------------------------
  // height divider: screen rows * world unit * 128 / distance
  // ---------------------------------------------------------------------------
  logic [21:0]   area;
  logic          hdiv_vld;
  logic [DL-1:0] hdiv_quo;

  assign area = sh_r * tile_r;

  sbp_div u_hdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (e_v_r),
    .dividend  ({4'b0000, area, 7'd0}),
    .divisor   (e_d_r),
    .valid_out (hdiv_vld),
    .quotient  (hdiv_quo)
  );

  // an extra register lines the height up with the column quotient
  logic          hq_v_r;
  logic [DL-1:0] hq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hq_v_r <= 1'b0;
    end else begin
      hq_v_r <= hdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    hq_r <= hdiv_quo;
  end

  // ---------------------------------------------------------------------------
  // f: column product, split into sign and magnitude for the divider
  // ---------------------------------------------------------------------------
  logic signed [31:0] colp;
  logic signed [31:0] colp_abs;

  assign colp     = e_ncol_r * $signed({1'b0, sw_r});
  assign colp_abs = colp[31] ? -colp : colp;

  logic        f_v_r;
  logic [29:0] f_mag_r;
  sb1_t        sb1_r [DL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f_mag_r       <= colp_abs[29:0];
    sb1_r[0].neg  <= colp[31];
    sb1_r[0].d    <= e_d_r;
    sb1_r[0].bear <= e_bear_r;
    sb1_r[0].fw   <= e_fw_r;
    sb1_r[0].fh   <= e_fh_r;
  end

  for (genvar k = 1; k <= DL; k++) begin : g_sb1
    always_ff @(posedge clk) begin
      sb1_r[k] <= sb1_r[k-1];
    end
  end

  // column divider: magnitude over twice the field of view, truncating
  logic          cdiv_vld;
  logic [DL-1:0] cdiv_quo;

  sbp_div u_cdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (f_v_r),
    .dividend  ({3'b000, f_mag_r}),
    .divisor   ({7'd0, fovn, 1'b0}),
    .valid_out (cdiv_vld),
    .quotient  (cdiv_quo)
  );

  // ---------------------------------------------------------------------------
  // g: saturated height and signed column
  // ---------------------------------------------------------------------------
  sb1_t               sb1_end;
  logic [19:0]        g_hsat;
  logic signed [30:0] g_cmag;

  assign sb1_end = sb1_r[DL];
  assign g_hsat  = (hq_r > DL'(SIZE_MAX)) ? SIZE_MAX : hq_r[19:0];
  assign g_cmag  = {1'b0, cdiv_quo[29:0]};

  logic        g_v_r;
  sb2_t        g_sb_r;
  logic [12:0] g_fw_r;
  logic [12:0] g_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else begin
      g_v_r <= cdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    g_sb_r.hs   <= g_hsat;
    g_sb_r.c    <= sb1_end.neg ? -g_cmag : g_cmag;
    g_sb_r.d    <= sb1_end.d;
    g_sb_r.bear <= sb1_end.bear;
    g_fw_r      <= sb1_end.fw;
    g_fh_r      <= sb1_end.fh;
  end

  // ---------------------------------------------------------------------------
  // k: aspect product for the width divider
  // ---------------------------------------------------------------------------
  logic          k_v_r;
  logic [DL-1:0] k_prod_r;
  logic [12:0]   k_fh_r;
  sb2_t          sb2_r [DL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else begin
      k_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    k_prod_r <= g_sb_r.hs * g_fw_r;
    // zero frame height reads as one
    k_fh_r   <= (g_fh_r == 13'd0) ? 13'd1 : g_fh_r;
    sb2_r[0] <= g_sb_r;
  end

  for (genvar k = 1; k <= DL; k++) begin : g_sb2
    always_ff @(posedge clk) begin
      sb2_r[k] <= sb2_r[k-1];
    end
  end

  logic          wdiv_vld;
  logic [DL-1:0] wdiv_quo;

  sbp_div u_wdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (k_v_r),
    .dividend  (k_prod_r),
    .divisor   ({11'd0, k_fh_r}),
    .valid_out (wdiv_vld),
    .quotient  (wdiv_quo)
  );

  // ---------------------------------------------------------------------------
  // output stage: width, left edge, cull test, top row
  // ---------------------------------------------------------------------------
  sb2_t               sb2_end;
  logic [19:0]        o_wsat;
  logic signed [31:0] o_left;
  logic signed [31:0] o_wsx;
  logic signed [31:0] o_hi;
  logic               o_vis;
  logic signed [20:0] o_leftsat;
  logic signed [21:0] o_tdiff;
  logic signed [21:0] o_tsum;

  assign sb2_end = sb2_r[DL];
  assign o_wsat  = (wdiv_quo > DL'(SIZE_MAX)) ? SIZE_MAX : wdiv_quo[19:0];
  assign o_left  = {sb2_end.c[30], sb2_end.c} - {13'd0, o_wsat[19:1]};
  assign o_wsx   = {12'd0, o_wsat};
  assign o_hi    = {19'd0, sw_r} + o_wsx;
  // cull on the unsaturated left edge
  assign o_vis   = !((o_left < -o_wsx) || (o_left >= o_hi));

  always_comb begin
    if (o_left < -32'sd1048576) begin
      o_leftsat = -21'sd1048576;
    end else if (o_left > 32'sd1048575) begin
      o_leftsat = 21'sd1048575;
    end else begin
      o_leftsat = o_left[20:0];
    end
  end

  // half of (height diff), truncated toward zero
  assign o_tdiff = {9'd0, sh_r} - {2'b00, sb2_end.hs};
  assign o_tsum  = o_tdiff + {21'd0, o_tdiff[21]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= wdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_out     <= sb2_end.d;
    out_relative_bearing <= sb2_end.bear;
    out_proj_height      <= sb2_end.hs;
    out_proj_width       <= o_wsat;
    out_left_column      <= o_leftsat;
    out_top_row          <= o_tsum[21:1];
    out_visible          <= o_vis;
  end

`ifndef SYNTHESIS
  // height quotient and column quotient belong to the same sprite
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    hq_v_r == cdiv_vld)
    else $error("height and column dividers out of step");

  // distance is clamped to at least 256
  a_dist_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_out >= 24'd256)
    else $error("distance below one unit");

  // zero height leaves nothing to scale into a width
  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_proj_height == 20'd0) |-> out_proj_width == 20'd0)
    else $error("nonzero width with zero height");

  // a result strobe comes only when the width divider reported a quotient
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(wdiv_vld))
    else $error("result strobe without a width quotient");
`endif

endmodule

// File: rtl/sbp_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module sbp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  logic [sbp_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [sbp_pkg::DIV_DEN_W-1:0] divisor,
  output logic                          valid_out,
  output logic [sbp_pkg::DIV_NUM_W-1:0] quotient
);
  import sbp_pkg::*;

  localparam int unsigned NW = DIV_NUM_W;
  localparam int unsigned DW = DIV_DEN_W;

  logic          vld_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [DW-1:0] rem_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          vld_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign vld_in = valid_in;
      assign num_in = dividend;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = divisor;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign num_in = num_r[k-1];
      assign quo_in = quo_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
    end

    // bring in the next dividend bit and try one subtract
    assign trial   = {rem_in, num_in[NW-1]};
    assign diff    = trial - {1'b0, den_in};
    assign take    = trial >= {1'b0, den_in};
    assign rem_nxt = take ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[k] <= {num_in[NW-2:0], 1'b0};
      quo_r[k] <= {quo_in[NW-2:0], take};
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_in;
    end
  end

  assign valid_out = vld_r[NW-1];
  assign quotient  = quo_r[NW-1];

endmodule
